### rtl/core/ptla_pkg.sv
// Shared constants, codes and control types of the peer table with LRU replacement and aging.
package ptla_pkg;

	// table geometry
	localparam int SLOTS = 16;
	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);

	// result field widths and their padded forms for truncation
	localparam int SLOT_W = 4;
	localparam int ACT_W = 5;
	localparam int SLOT_EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
	localparam int ACT_EXT_W = (CNT_W > ACT_W) ? CNT_W : ACT_W;

	// configuration port
	localparam int PADDR_W = 3;
	localparam logic REG_IDLE_TIMEOUT = 1'b0;
	localparam logic [31:0] TIMEOUT_RESET = 32'd60000;

	// item kinds
	localparam logic KIND_OBSERVE = 1'b0;
	localparam logic KIND_SWEEP = 1'b1;

	typedef enum logic [1:0] {
		OUT_UPDATED  = 2'd0,
		OUT_INSERTED = 2'd1,
		OUT_EVICTED  = 2'd2,
		OUT_SWEEP    = 2'd3
	} outcome_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_SCAN   = 2'd1,
		ST_COMMIT = 2'd2,
		ST_PUSH   = 2'd3
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic commit;
		logic push;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;
	} status_t;

endpackage

### rtl/core/peer_table_lru_aging.sv
// Top level of the peer table: configuration register, sequencer and datapath.
//
// Usage: the input channel (in_valid/in_ready) carries one item per beat:
// kind 0 observes a peer packet (peer_id, rssi, now_ms), kind 1 sweeps out
// entries idle longer than idle_timeout_ms. Every item gives exactly one
// result beat on the output channel (out_valid/out_ready): outcome, slot,
// peer_packets, active_count and total_peers.
// Flow: the block handles one item at a time. After the input beat it scans
// every table slot in turn through a single read port, then commits the
// chosen entry and hands the result off, and it takes no new item until
// that hand-off is done.
// The result sits in an output register; the next item is accepted while it
// waits, and if the receiver still stalls when that item is done, the block
// holds it until the earlier beat is taken. idle_timeout_ms is at byte
// address 0 of the APB port; the user must write it only while no item is in
// flight, and the block does not enforce this. Reset clears all valid bits,
// the counters and both channels, and sets the timeout to 60000 ms.
module peer_table_lru_aging (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ptla_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          kind,
	input  logic [63:0]                   peer_id,
	input  logic signed [7:0]             rssi,
	input  logic [31:0]                   now_ms,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    outcome,
	output logic [3:0]                    slot,
	output logic [31:0]                   peer_packets,
	output logic [4:0]                    active_count,
	output logic [31:0]                   total_peers
);
	import ptla_pkg::*;

	logic [31:0] timeout_q;
	logic        reg_sel;
	cmd_t        cmd;
	status_t     status;

	assign pready = 1'b1;
	assign reg_sel = (paddr[PADDR_W-1] == REG_IDLE_TIMEOUT);

	// write the timeout register on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			timeout_q <= pwdata;
		end
	end

	// return the register, zero elsewhere
	assign prdata = reg_sel ? timeout_q : 32'd0;

	ptla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	ptla_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.kind         (kind),
		.peer_id      (peer_id),
		.rssi         (rssi),
		.now_ms       (now_ms),
		.idle_timeout (timeout_q),
		.outcome      (outcome),
		.slot         (slot),
		.peer_packets (peer_packets),
		.active_count (active_count),
		.total_peers  (total_peers)
	);

	// an accepted item reaches commit after exactly one pass over the table
	a_scan_length: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##(SLOTS + 1) cmd.commit)
		else $error("commit not reached after full table scan");

	// a new output beat only comes from a hand-off
	a_beat_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.push))
		else $error("output beat raised without hand-off");

	// a sweep beat carries no slot and no packet count
	a_sweep_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (outcome == OUT_SWEEP) |-> (slot == '0) && (peer_packets == '0))
		else $error("sweep beat with nonzero slot or packet count");

	// the scan never runs while a new beat is being taken
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step || cmd.commit |-> !in_ready)
		else $error("input taken while a scan or commit is active");

endmodule

### rtl/core/ptla_ctrl.sv
// Sequencer for the peer table: accept, scan all slots, commit, hand off the result.
module ptla_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  ptla_pkg::status_t status,
	output ptla_pkg::cmd_t    cmd
);
	import ptla_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	// state register and output beat flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.step = 1'b1;
				if (status.scan_last) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d = ST_PUSH;
			end
			ST_PUSH: begin
				if (!out_valid_q || out_ready) begin
					cmd.push = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/core/ptla_dpath.sv
// Peer table storage, slot scan, update logic and result register.
module ptla_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  ptla_pkg::cmd_t    cmd,
	output ptla_pkg::status_t status,
	input  logic              kind,
	input  logic [63:0]       peer_id,
	input  logic signed [7:0] rssi,
	input  logic [31:0]       now_ms,
	input  logic [31:0]       idle_timeout,
	output logic [1:0]        outcome,
	output logic [3:0]        slot,
	output logic [31:0]       peer_packets,
	output logic [4:0]        active_count,
	output logic [31:0]       total_peers
);
	import ptla_pkg::*;

	// captured item
	logic              kind_q;
	logic [63:0]       id_q;
	logic signed [7:0] rssi_q;
	logic [31:0]       now_q;

	// table
	logic [63:0]       ent_id_q   [SLOTS];
	logic signed [7:0] ent_rssi_q [SLOTS];
	logic [31:0]       ent_seen_q [SLOTS];
	logic [31:0]       ent_pk_q   [SLOTS];
	logic [SLOTS-1:0]  valid_q;
	logic [31:0]       total_q;
	logic [ACT_W-1:0]  last_act_q;

	// scan state
	logic [IDX_W-1:0]  idx_q;
	logic              hit_q;
	logic [IDX_W-1:0]  hit_idx_q;
	logic [31:0]       hit_pk_q;
	logic              free_q;
	logic [IDX_W-1:0]  free_idx_q;
	logic [31:0]       best_age_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [CNT_W-1:0]  cnt_q;

	// result held between commit and hand-off
	outcome_t          res_outcome_q;
	logic [IDX_W-1:0]  res_slot_q;
	logic [31:0]       res_pk_q;

	// output beat
	outcome_t          out_outcome_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [31:0]       out_pk_q;
	logic [ACT_W-1:0]  out_act_q;
	logic [31:0]       out_total_q;

	logic              rd_valid;
	logic [31:0]       rd_seen;
	logic [31:0]       age;
	logic              stale;
	logic              is_match;
	logic [IDX_W-1:0]  sel_idx;
	logic              is_observe;
	logic [SLOT_EXT_W-1:0] slot_ext;
	logic [ACT_EXT_W-1:0]  act_ext;

	// read the slot under scan
	assign rd_valid = valid_q[idx_q];
	assign rd_seen = ent_seen_q[idx_q];
	assign age = now_q - rd_seen;
	assign stale = age > idle_timeout;
	assign is_match = rd_valid && (ent_id_q[idx_q] == id_q);
	assign is_observe = (kind_q == KIND_OBSERVE);
	assign status.scan_last = (idx_q == IDX_W'(SLOTS - 1));

	// pick target slot: hit, else lowest free, else oldest
	always_comb begin
		if (hit_q) begin
			sel_idx = hit_idx_q;
		end else if (free_q) begin
			sel_idx = free_idx_q;
		end else begin
			sel_idx = best_idx_q;
		end
	end

	assign slot_ext = SLOT_EXT_W'(res_slot_q);
	assign act_ext = ACT_EXT_W'(cnt_q);

	// valid bits and running counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			total_q <= '0;
			last_act_q <= '0;
		end else begin
			if (cmd.step && !is_observe && rd_valid && stale) begin
				valid_q[idx_q] <= 1'b0;
			end
			if (cmd.commit) begin
				if (is_observe) begin
					valid_q[sel_idx] <= 1'b1;
					if (!hit_q && free_q) begin
						total_q <= total_q + 32'd1;
					end
				end else begin
					last_act_q <= act_ext[ACT_W-1:0];
				end
			end
		end
	end

	// capture item and scan the table
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			id_q <= peer_id;
			rssi_q <= rssi;
			now_q <= now_ms;
			idx_q <= '0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			cnt_q <= '0;
		end
		if (cmd.step) begin
			idx_q <= idx_q + IDX_W'(1);
			if (is_observe) begin
				if (is_match && !hit_q) begin
					hit_q <= 1'b1;
					hit_idx_q <= idx_q;
					hit_pk_q <= ent_pk_q[idx_q];
				end
				if (!rd_valid && !free_q) begin
					free_q <= 1'b1;
					free_idx_q <= idx_q;
				end
				if ((idx_q == '0) || (age > best_age_q)) begin
					best_age_q <= age;
					best_idx_q <= idx_q;
				end
			end else if (rd_valid && !stale) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// write the chosen entry and form the result
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (is_observe) begin
				ent_rssi_q[sel_idx] <= rssi_q;
				ent_seen_q[sel_idx] <= now_q;
				res_slot_q <= sel_idx;
				if (hit_q) begin
					ent_pk_q[sel_idx] <= hit_pk_q + 32'd1;
					res_pk_q <= hit_pk_q + 32'd1;
					res_outcome_q <= OUT_UPDATED;
				end else begin
					ent_id_q[sel_idx] <= id_q;
					ent_pk_q[sel_idx] <= 32'd1;
					res_pk_q <= 32'd1;
					res_outcome_q <= free_q ? OUT_INSERTED : OUT_EVICTED;
				end
			end else begin
				res_slot_q <= '0;
				res_pk_q <= '0;
				res_outcome_q <= OUT_SWEEP;
			end
		end
	end

	// load the output beat
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_outcome_q <= res_outcome_q;
			out_slot_q <= slot_ext[SLOT_W-1:0];
			out_pk_q <= res_pk_q;
			out_act_q <= last_act_q;
			out_total_q <= total_q;
		end
	end

	assign outcome = out_outcome_q;
	assign slot = out_slot_q;
	assign peer_packets = out_pk_q;
	assign active_count = out_act_q;
	assign total_peers = out_total_q;

endmodule
